[sv/stt_pkg.sv]
// Shared types, token codes and keyword table for the source text tokenizer.
package stt_pkg;

  localparam int POS_WIDTH = 32;
  localparam int LEN_WIDTH = 16;
  localparam int PREFIX_WIDTH = 48;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_WIDTH = $clog2(QUEUE_DEPTH);
  localparam int QCNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

  localparam logic [4:0] TT_IDENT    = 5'd0;
  localparam logic [4:0] TT_BASETYPE = 5'd1;
  localparam logic [4:0] TT_KEYWORD  = 5'd2;
  localparam logic [4:0] TT_NUMBER   = 5'd3;
  localparam logic [4:0] TT_DIV      = 5'd4;
  localparam logic [4:0] TT_ADD      = 5'd5;
  localparam logic [4:0] TT_SUB      = 5'd6;
  localparam logic [4:0] TT_MUL      = 5'd7;
  localparam logic [4:0] TT_ASSIGN   = 5'd8;
  localparam logic [4:0] TT_COMMA    = 5'd9;
  localparam logic [4:0] TT_SEMI     = 5'd10;
  localparam logic [4:0] TT_LBRACE   = 5'd11;
  localparam logic [4:0] TT_RBRACE   = 5'd12;
  localparam logic [4:0] TT_LPAREN   = 5'd13;
  localparam logic [4:0] TT_RPAREN   = 5'd14;
  localparam logic [4:0] TT_LBRACKET = 5'd15;
  localparam logic [4:0] TT_RBRACKET = 5'd16;

  localparam logic [2:0] WC_NONE   = 3'd0;
  localparam logic [2:0] WC_VOID   = 3'd1;
  localparam logic [2:0] WC_U64    = 3'd2;
  localparam logic [2:0] WC_IF     = 3'd3;
  localparam logic [2:0] WC_ELSE   = 3'd4;
  localparam logic [2:0] WC_SWITCH = 3'd5;
  localparam logic [2:0] WC_RETURN = 3'd6;

  // Reserved words packed first byte lowest, as the word prefix is collected.
  localparam logic [PREFIX_WIDTH-1:0] PACK_VOID   = 48'h0000_6469_6F76;
  localparam logic [PREFIX_WIDTH-1:0] PACK_U64    = 48'h0000_0034_3675;
  localparam logic [PREFIX_WIDTH-1:0] PACK_IF     = 48'h0000_0000_6669;
  localparam logic [PREFIX_WIDTH-1:0] PACK_ELSE   = 48'h0000_6573_6C65;
  localparam logic [PREFIX_WIDTH-1:0] PACK_SWITCH = 48'h6863_7469_7773;
  localparam logic [PREFIX_WIDTH-1:0] PACK_RETURN = 48'h6E72_7574_6572;

  typedef enum logic [2:0] {
    MODE_NORMAL,
    MODE_SLASH,
    MODE_BLOCK,
    MODE_BLOCK_STAR,
    MODE_LINE
  } lex_mode_t;

  // One raw token: either a finished word still to be classified or a fixed token.
  typedef struct packed {
    logic                    is_word;
    logic [4:0]              ttype;
    logic [POS_WIDTH-1:0]    start;
    logic [LEN_WIDTH-1:0]    len;
    logic [PREFIX_WIDTH-1:0] prefix;
    logic                    all_digits;
  } tok_t;

  // All tokens caused by one input byte.
  typedef struct packed {
    logic two;
    tok_t tok0;
    tok_t tok1;
  } bundle_t;

endpackage

[sv/source_text_tokenizer.sv]
// Top level of the source text tokenizer: lexer front end, bundle queue, output stage.
//
// Usage: source bytes enter on the input queue port. A byte transfers at a rising
// edge with push high and full low; in_end_of_input marks the last byte of a stream,
// after which positions restart at zero. Tokens leave on the result queue port: the
// oldest token sits on the out_ ports while empty is low and transfers at an edge
// with pop high. out_run_last is set on the final token caused by a given byte.
// One byte is taken every cycle while full is low. Each byte yields zero, one or two
// tokens; the front end packs those of each byte that yields any into one bundle and
// writes it into a four-entry queue. The output stage hands out one token per cycle
// while pop is high, so the two tokens of a byte leave one after the other; the output
// stage sets the sustained rate whenever tokens arrive faster than one per cycle.
// When nothing waits ahead of it, a token appears on the result ports once the output
// register loads: the bundle is written into the queue at its byte's transfer edge
// itself and the output register loads at the following edge.
// When the receiver stalls, the queue fills and full rises; bytes are then held
// off while lexer state stays put, so no token is lost or repeated.
// Reset (synchronous, active low) empties the queue and output register and puts
// the lexer at position zero in normal mode with no pending word.
module source_text_tokenizer
  import stt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  logic [7:0]           in_byte,
  input  logic                 in_end_of_input,
  output logic                 empty,
  input  logic                 pop,
  output logic [4:0]           out_token_type,
  output logic [2:0]           out_word_code,
  output logic [POS_WIDTH-1:0] out_start_pos,
  output logic [LEN_WIDTH-1:0] out_token_length,
  output logic                 out_run_last
);

  logic    accept;
  logic    bundle_valid;
  bundle_t bundle;
  bundle_t q_head;
  logic    q_empty;
  logic    q_pop;

  // A byte transfer advances lexer state exactly once.
  assign accept = push && !full;

  stt_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .byte_i       (in_byte),
    .last_i       (in_end_of_input),
    .bundle_valid (bundle_valid),
    .bundle       (bundle)
  );

  // The queue decouples the lexer from a stalled receiver.
  stt_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (bundle_valid),
    .wdata (bundle),
    .full  (full),
    .pop   (q_pop),
    .rdata (q_head),
    .empty (q_empty)
  );

  // The output stage classifies words and presents one token at a time.
  stt_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .empty        (empty),
    .pop          (pop),
    .token_type   (out_token_type),
    .word_code    (out_word_code),
    .start_pos    (out_start_pos),
    .token_length (out_token_length),
    .run_last     (out_run_last)
  );

endmodule

[sv/stt_front.sv]
// Front end: per-byte lexer state machine that builds raw token bundles.
module stt_front
  import stt_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  logic [7:0]    byte_i,
  input  logic          last_i,
  output logic          bundle_valid,
  output bundle_t       bundle
);

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  lex_mode_t                mode_r, mode_nxt;
  logic [POS_WIDTH-1:0]     pos_r, pos_nxt;
  logic [POS_WIDTH-1:0]     wstart_r, wstart_nxt;
  logic [LEN_WIDTH-1:0]     wlen_r, wlen_nxt;
  logic [PREFIX_WIDTH-1:0]  wprefix_r, wprefix_nxt;
  logic                     wdig_r, wdig_nxt;

  logic [1:0]               n;
  tok_t                     tok0, tok1;
  logic                     run_normal;
  logic [4:0]               pt;
  logic [5:0]               shift;

  function automatic logic [4:0] punct_type(input logic [7:0] c);
    logic [4:0] t;
    unique case (c)
      8'h2B:   t = TT_ADD;
      8'h2D:   t = TT_SUB;
      8'h2A:   t = TT_MUL;
      8'h3D:   t = TT_ASSIGN;
      8'h2C:   t = TT_COMMA;
      8'h3B:   t = TT_SEMI;
      8'h7B:   t = TT_LBRACE;
      8'h7D:   t = TT_RBRACE;
      8'h28:   t = TT_LPAREN;
      8'h29:   t = TT_RPAREN;
      8'h5B:   t = TT_LBRACKET;
      8'h5D:   t = TT_RBRACKET;
      default: t = TT_IDENT;
    endcase
    return t;
  endfunction

  function automatic tok_t mk_fixed(input logic [4:0] t, input logic [POS_WIDTH-1:0] s);
    tok_t r;
    r            = '0;
    r.ttype      = t;
    r.start      = s;
    r.len        = LEN_WIDTH'(1);
    return r;
  endfunction

  function automatic tok_t mk_word(input logic [POS_WIDTH-1:0] s,
                                   input logic [LEN_WIDTH-1:0] l,
                                   input logic [PREFIX_WIDTH-1:0] p,
                                   input logic d);
    tok_t r;
    r.is_word    = 1'b1;
    r.ttype      = TT_IDENT;
    r.start      = s;
    r.len        = l;
    r.prefix     = p;
    r.all_digits = d;
    return r;
  endfunction

  always_comb begin
    mode_nxt    = mode_r;
    wstart_nxt  = wstart_r;
    wlen_nxt    = wlen_r;
    wprefix_nxt = wprefix_r;
    wdig_nxt    = wdig_r;
    n           = 2'd0;
    tok0        = '0;
    tok1        = '0;
    run_normal  = 1'b0;
    pt          = punct_type(byte_i);
    shift       = {wlen_r[2:0], 3'b000};

    unique case (mode_r)
      MODE_SLASH: begin
        if (byte_i == CH_STAR) begin
          mode_nxt = MODE_BLOCK;
        end else if (byte_i == CH_SLASH) begin
          mode_nxt = MODE_LINE;
        end else begin
          tok0       = mk_fixed(TT_DIV, pos_r - POS_WIDTH'(1));
          n          = 2'd1;
          mode_nxt   = MODE_NORMAL;
          run_normal = 1'b1;
        end
      end
      MODE_BLOCK: begin
        if (byte_i == CH_STAR) mode_nxt = MODE_BLOCK_STAR;
      end
      MODE_BLOCK_STAR: begin
        if (byte_i == CH_SLASH) mode_nxt = MODE_NORMAL;
        else if (byte_i != CH_STAR) mode_nxt = MODE_BLOCK;
      end
      MODE_LINE: begin
        if (byte_i == CH_NL) mode_nxt = MODE_NORMAL;
      end
      default: begin
        mode_nxt   = MODE_NORMAL;
        run_normal = 1'b1;
      end
    endcase

    if (run_normal) begin
      if (byte_i == CH_SPACE || byte_i == CH_TAB || byte_i == CH_NL ||
          pt != TT_IDENT || byte_i == CH_SLASH) begin
        // Any delimiter finishes the pending word first.
        if (wlen_nxt != '0) begin
          if (n == 2'd0) tok0 = mk_word(wstart_nxt, wlen_nxt, wprefix_nxt, wdig_nxt);
          else           tok1 = mk_word(wstart_nxt, wlen_nxt, wprefix_nxt, wdig_nxt);
          n           = n + 2'd1;
          wstart_nxt  = '0;
          wlen_nxt    = '0;
          wprefix_nxt = '0;
          wdig_nxt    = 1'b1;
        end
        if (pt != TT_IDENT) begin
          if (n == 2'd0) tok0 = mk_fixed(pt, pos_r);
          else           tok1 = mk_fixed(pt, pos_r);
          n = n + 2'd1;
        end else if (byte_i == CH_SLASH) begin
          mode_nxt = MODE_SLASH;
        end
      end else begin
        if (wlen_r == '0) wstart_nxt = pos_r;
        if (wlen_r < LEN_WIDTH'(6)) wprefix_nxt[shift +: 8] = wprefix_r[shift +: 8] | byte_i;
        if (byte_i < CH_ZERO || byte_i > CH_NINE) wdig_nxt = 1'b0;
        if (wlen_r != '1) wlen_nxt = wlen_r + LEN_WIDTH'(1);
      end
    end

    if (last_i) begin
      if (mode_nxt == MODE_SLASH) begin
        if (n == 2'd0) tok0 = mk_fixed(TT_DIV, pos_r);
        else           tok1 = mk_fixed(TT_DIV, pos_r);
        n = n + 2'd1;
      end
      if (wlen_nxt != '0) begin
        if (n == 2'd0) tok0 = mk_word(wstart_nxt, wlen_nxt, wprefix_nxt, wdig_nxt);
        else           tok1 = mk_word(wstart_nxt, wlen_nxt, wprefix_nxt, wdig_nxt);
        n = n + 2'd1;
      end
      mode_nxt    = MODE_NORMAL;
      wstart_nxt  = '0;
      wlen_nxt    = '0;
      wprefix_nxt = '0;
      wdig_nxt    = 1'b1;
      pos_nxt     = '0;
    end else begin
      pos_nxt = pos_r + POS_WIDTH'(1);
    end
  end

  assign bundle_valid = accept && (n != 2'd0);
  assign bundle.two   = (n == 2'd2);
  assign bundle.tok0  = tok0;
  assign bundle.tok1  = tok1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_NORMAL;
      pos_r     <= '0;
      wstart_r  <= '0;
      wlen_r    <= '0;
      wprefix_r <= '0;
      wdig_r    <= 1'b1;
    end else if (accept) begin
      mode_r    <= mode_nxt;
      pos_r     <= pos_nxt;
      wstart_r  <= wstart_nxt;
      wlen_r    <= wlen_nxt;
      wprefix_r <= wprefix_nxt;
      wdig_r    <= wdig_nxt;
    end
  end

  // The last byte of a stream always leaves the lexer back at its start.
  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    accept && last_i |=> mode_r == MODE_NORMAL && pos_r == '0 && wlen_r == '0)
    else $error("lexer not restarted after end of input");

endmodule

[sv/stt_queue.sv]
// Short queue of token bundles between the lexer front end and the output stage.
module stt_queue
  import stt_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  bundle_t wdata,
  output logic    full,
  input  logic    pop,
  output bundle_t rdata,
  output logic    empty
);

  bundle_t                mem_r [QUEUE_DEPTH];
  logic [QPTR_WIDTH-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QCNT_WIDTH-1:0]  cnt_r;

  assign full  = (cnt_r == QCNT_WIDTH'(QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QPTR_WIDTH'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QPTR_WIDTH'(1);
      if (push && !pop)      cnt_r <= cnt_r + QCNT_WIDTH'(1);
      else if (pop && !push) cnt_r <= cnt_r - QCNT_WIDTH'(1);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("bundle written into a full queue");

endmodule

[sv/stt_back.sv]
// Output stage: classifies words and serializes bundles into single tokens.
module stt_back
  import stt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_empty,
  input  bundle_t              q_head,
  output logic                 q_pop,
  output logic                 empty,
  input  logic                 pop,
  output logic [4:0]           token_type,
  output logic [2:0]           word_code,
  output logic [POS_WIDTH-1:0] start_pos,
  output logic [LEN_WIDTH-1:0] token_length,
  output logic                 run_last
);

  logic                 valid_r, valid_nxt;
  logic                 sel_r, sel_nxt;
  logic [4:0]           type_r;
  logic [2:0]           code_r;
  logic [POS_WIDTH-1:0] start_r;
  logic [LEN_WIDTH-1:0] len_r;
  logic                 last_r;

  logic                 load;
  tok_t                 cur;
  logic [4:0]           cls_type;
  logic [2:0]           cls_code;

  assign cur  = sel_r ? q_head.tok1 : q_head.tok0;
  assign load = !q_empty && (!valid_r || pop);

  always_comb begin
    cls_type = cur.ttype;
    cls_code = WC_NONE;
    if (cur.is_word) begin
      priority if (cur.len == LEN_WIDTH'(4) && cur.prefix == PACK_VOID) begin
        cls_type = TT_BASETYPE; cls_code = WC_VOID;
      end else if (cur.len == LEN_WIDTH'(3) && cur.prefix == PACK_U64) begin
        cls_type = TT_BASETYPE; cls_code = WC_U64;
      end else if (cur.len == LEN_WIDTH'(2) && cur.prefix == PACK_IF) begin
        cls_type = TT_KEYWORD; cls_code = WC_IF;
      end else if (cur.len == LEN_WIDTH'(4) && cur.prefix == PACK_ELSE) begin
        cls_type = TT_KEYWORD; cls_code = WC_ELSE;
      end else if (cur.len == LEN_WIDTH'(6) && cur.prefix == PACK_SWITCH) begin
        cls_type = TT_KEYWORD; cls_code = WC_SWITCH;
      end else if (cur.len == LEN_WIDTH'(6) && cur.prefix == PACK_RETURN) begin
        cls_type = TT_KEYWORD; cls_code = WC_RETURN;
      end else if (cur.all_digits) begin
        cls_type = TT_NUMBER;
      end else begin
        cls_type = TT_IDENT;
      end
    end
  end

  always_comb begin
    q_pop     = load && (sel_r || !q_head.two);
    sel_nxt   = load ? (q_head.two && !sel_r) : sel_r;
    valid_nxt = load ? 1'b1 : (valid_r && !pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sel_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      sel_r   <= sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      type_r  <= cls_type;
      code_r  <= cls_code;
      start_r <= cur.start;
      len_r   <= cur.len;
      last_r  <= sel_r || !q_head.two;
    end
  end

  assign empty        = !valid_r;
  assign token_type   = type_r;
  assign word_code    = code_r;
  assign start_pos    = start_r;
  assign token_length = len_r;
  assign run_last     = last_r;

  a_sel_on_pair: assert property (@(posedge clk) disable iff (!rst_n)
    sel_r |-> !q_empty && q_head.two)
    else $error("second token selected without a two-token bundle");

  a_pair_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    load && !q_pop |=> sel_r && valid_r && !last_r)
    else $error("first token of a pair marked as last");

endmodule

[tb/source_text_tokenizer_tb.sv]
// Self-checking testbench for the source text tokenizer with a built-in lexer predictor.
module source_text_tokenizer_tb;
  import stt_pkg::*;

  // The run is stopped here no matter what.
  localparam int CYCLE_LIMIT = 1_000_000;
  // Least number of bytes in the random part of the run.
  localparam int RANDOM_BYTES = 1650;
  // Cycles to watch for stray tokens once everything expected has arrived.
  localparam int SETTLE_CYCLES = 20;

  // One source byte waiting to go out, with the idle cycles that come before it.
  // A byte with hold_for_drain set is not sent until every predicted token has
  // been received.
  typedef struct {
    logic [7:0] value;
    logic       last;
    int         gap;
    bit         hold_for_drain;
  } src_byte_t;

  // One token as the block should report it.
  typedef struct {
    logic [4:0]           ttype;
    logic [2:0]           code;
    logic [POS_WIDTH-1:0] start;
    logic [LEN_WIDTH-1:0] len;
    logic                 last;
  } token_t;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 push = 1'b0;
  logic                 full;
  logic [7:0]           in_byte = 8'h00;
  logic                 in_end_of_input = 1'b0;
  logic                 empty;
  logic                 pop = 1'b0;
  logic [4:0]           out_token_type;
  logic [2:0]           out_word_code;
  logic [POS_WIDTH-1:0] out_start_pos;
  logic [LEN_WIDTH-1:0] out_token_length;
  logic                 out_run_last;

  source_text_tokenizer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_byte          (in_byte),
    .in_end_of_input  (in_end_of_input),
    .empty            (empty),
    .pop              (pop),
    .out_token_type   (out_token_type),
    .out_word_code    (out_word_code),
    .out_start_pos    (out_start_pos),
    .out_token_length (out_token_length),
    .out_run_last     (out_run_last)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Source bytes not yet put on the input port, and tokens predicted but not yet received.
  src_byte_t text_q[$];
  token_t    due_tokens[$];
  token_t    byte_tokens[$];

  int  tokens_predicted = 0;
  int  tokens_received = 0;
  int  mismatches = 0;
  int  cycle_count = 0;
  int  idle_cycles = 0;
  int  stall_left = 0;
  int  rx_max = 19;
  int  send_max = 0;
  bit  drain_next = 1'b0;

  src_byte_t next_src;
  token_t    want;

  // Predictor state: a private copy of the lexer's mode, position and pending word.
  lex_mode_t               lx_mode;
  logic [POS_WIDTH-1:0]    lx_pos;
  logic [POS_WIDTH-1:0]    lx_word_start;
  logic [LEN_WIDTH-1:0]    lx_word_len;
  logic [PREFIX_WIDTH-1:0] lx_prefix;
  logic                    lx_digits;

  // ---------------------------------------------------------------------------
  // Lexer predictor
  // ---------------------------------------------------------------------------

  function automatic void lex_reset();
    lx_mode       = MODE_NORMAL;
    lx_pos        = '0;
    lx_word_start = '0;
    lx_word_len   = '0;
    lx_prefix     = '0;
    lx_digits     = 1'b1;
  endfunction

  function automatic void add_token(logic [4:0] ttype, logic [2:0] code,
                                    logic [POS_WIDTH-1:0] start, logic [LEN_WIDTH-1:0] len);
    token_t tk;
    tk.ttype = ttype;
    tk.code  = code;
    tk.start = start;
    tk.len   = len;
    tk.last  = 1'b0;
    byte_tokens.push_back(tk);
  endfunction

  // Operator and punctuation characters map to their token type; every other
  // byte maps to TT_IDENT, which here means "not a single-character token".
  function automatic logic [4:0] punct_code(logic [7:0] b);
    case (b)
      "+": return TT_ADD;
      "-": return TT_SUB;
      "*": return TT_MUL;
      "=": return TT_ASSIGN;
      ",": return TT_COMMA;
      ";": return TT_SEMI;
      "{": return TT_LBRACE;
      "}": return TT_RBRACE;
      "(": return TT_LPAREN;
      ")": return TT_RPAREN;
      "[": return TT_LBRACKET;
      "]": return TT_RBRACKET;
      default: return TT_IDENT;
    endcase
  endfunction

  // Classifies and reports the pending word, if there is one, then clears it.
  // Reserved words must match in both length and prefix, so a longer word that
  // merely starts with one stays an identifier.
  function automatic void close_word();
    logic [4:0] ttype;
    logic [2:0] code;
    if (lx_word_len == '0) return;
    ttype = lx_digits ? TT_NUMBER : TT_IDENT;
    code  = WC_NONE;
    if (lx_word_len == 4 && lx_prefix == PACK_VOID) begin
      ttype = TT_BASETYPE;
      code  = WC_VOID;
    end else if (lx_word_len == 3 && lx_prefix == PACK_U64) begin
      ttype = TT_BASETYPE;
      code  = WC_U64;
    end else if (lx_word_len == 2 && lx_prefix == PACK_IF) begin
      ttype = TT_KEYWORD;
      code  = WC_IF;
    end else if (lx_word_len == 4 && lx_prefix == PACK_ELSE) begin
      ttype = TT_KEYWORD;
      code  = WC_ELSE;
    end else if (lx_word_len == 6 && lx_prefix == PACK_SWITCH) begin
      ttype = TT_KEYWORD;
      code  = WC_SWITCH;
    end else if (lx_word_len == 6 && lx_prefix == PACK_RETURN) begin
      ttype = TT_KEYWORD;
      code  = WC_RETURN;
    end
    add_token(ttype, code, lx_word_start, lx_word_len);
    lx_word_start = '0;
    lx_word_len   = '0;
    lx_prefix     = '0;
    lx_digits     = 1'b1;
  endfunction

  // Handling of one byte outside any comment or pending slash.
  function automatic void plain_byte(logic [7:0] b, logic [POS_WIDTH-1:0] pos);
    logic [4:0] pt;
    pt = punct_code(b);
    if (b == " " || b == "\t" || b == "\n") begin
      close_word();
    end else if (pt != TT_IDENT) begin
      close_word();
      add_token(pt, WC_NONE, pos, LEN_WIDTH'(1));
    end else if (b == "/") begin
      close_word();
      lx_mode = MODE_SLASH;
    end else begin
      // Any other byte, zero and bytes above 127 included, extends the word.
      if (lx_word_len == '0) lx_word_start = pos;
      if (lx_word_len < 6) lx_prefix[8*lx_word_len +: 8] = b;
      if (b < "0" || b > "9") lx_digits = 1'b0;
      if (lx_word_len != '1) lx_word_len++;
    end
  endfunction

  // Predicts every token caused by one transferred byte and queues them.
  function automatic void lex_byte(logic [7:0] b, logic last);
    logic [POS_WIDTH-1:0] pos;
    pos = lx_pos;
    byte_tokens.delete();
    case (lx_mode)
      MODE_SLASH: begin
        if (b == "*") begin
          lx_mode = MODE_BLOCK;
        end else if (b == "/") begin
          lx_mode = MODE_LINE;
        end else begin
          // The held slash was a division; it goes out before this byte's token.
          add_token(TT_DIV, WC_NONE, pos - POS_WIDTH'(1), LEN_WIDTH'(1));
          lx_mode = MODE_NORMAL;
          plain_byte(b, pos);
        end
      end
      MODE_BLOCK: begin
        if (b == "*") lx_mode = MODE_BLOCK_STAR;
      end
      MODE_BLOCK_STAR: begin
        if (b == "/") lx_mode = MODE_NORMAL;
        else if (b != "*") lx_mode = MODE_BLOCK;
      end
      MODE_LINE: begin
        if (b == "\n") lx_mode = MODE_NORMAL;
      end
      default: begin
        lx_mode = MODE_NORMAL;
        plain_byte(b, pos);
      end
    endcase
    if (last) begin
      // End of input: a held slash and a pending word are flushed, an open
      // comment is dropped, and positions start over.
      if (lx_mode == MODE_SLASH) add_token(TT_DIV, WC_NONE, pos, LEN_WIDTH'(1));
      close_word();
      lex_reset();
    end else begin
      lx_pos = pos + POS_WIDTH'(1);
    end
    if (byte_tokens.size() != 0) byte_tokens[byte_tokens.size()-1].last = 1'b1;
    foreach (byte_tokens[i]) due_tokens.push_back(byte_tokens[i]);
    tokens_predicted += byte_tokens.size();
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------

  function automatic void queue_byte(logic [7:0] b);
    src_byte_t it;
    it.value          = b;
    it.last           = 1'b0;
    it.gap            = $urandom_range(send_max, 0);
    it.hold_for_drain = drain_next;
    drain_next        = 1'b0;
    text_q.push_back(it);
  endfunction

  function automatic void queue_text(string s);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
  endfunction

  // Marks the most recently queued byte as the end of its input stream.
  function automatic void end_stream();
    text_q[text_q.size()-1].last = 1'b1;
  endfunction

  function automatic void pick_send_pace();
    case ($urandom_range(2, 0))
      0:       send_max = 0;
      1:       send_max = 3;
      default: send_max = 19;
    endcase
  endfunction

  // One random stream: mostly well-formed source with random content, some
  // raw noise, and the occasional unclosed comment. Every stream ends with an
  // end-of-input byte, which lands at any point of a word, comment or slash.
  function automatic void queue_stream();
    string      word_pool[] = '{"void", "u64", "if", "else", "switch", "return",
                                "voids", "u6", "iff", "els", "switchy", "Return",
                                "returns", "if0", "u64u64", "elsee"};
    string      puncts = "+-*=,;{}()[]";
    string      seps = " \t\n";
    string      comment_chars = "**/a \n";
    int         pieces;
    int         count;
    logic [7:0] b;
    pieces = $urandom_range(30, 1);
    // Now and then a stream of nothing but uniform random bytes.
    if ($urandom_range(9, 0) == 0) begin
      for (int i = 0; i < pieces; i++) queue_byte($urandom_range(255, 0));
      end_stream();
      return;
    end
    for (int p = 0; p < pieces; p++) begin
      case ($urandom_range(11, 0))
        0, 1: queue_text(word_pool[$urandom_range(word_pool.size() - 1, 0)]);
        2: begin
          count = $urandom_range(8, 1);
          for (int i = 0; i < count; i++) queue_byte("0" + $urandom_range(9, 0));
        end
        3: begin
          // Identifier bytes drawn from the whole byte range.
          count = $urandom_range(9, 1);
          for (int i = 0; i < count; i++) begin
            do b = $urandom_range(255, 0);
            while (b == " " || b == "\t" || b == "\n" || b == "/" ||
                   punct_code(b) != TT_IDENT);
            queue_byte(b);
          end
        end
        4, 5: queue_byte(puncts[$urandom_range(puncts.len() - 1, 0)]);
        6: begin
          count = $urandom_range(3, 1);
          for (int i = 0; i < count; i++) queue_byte(seps[$urandom_range(2, 0)]);
        end
        7: begin
          queue_text("/*");
          count = $urandom_range(8, 0);
          for (int i = 0; i < count; i++)
            queue_byte(comment_chars[$urandom_range(comment_chars.len() - 1, 0)]);
          queue_text("*/");
        end
        8: begin
          queue_text("//");
          count = $urandom_range(8, 0);
          for (int i = 0; i < count; i++) begin
            do b = $urandom_range(255, 0);
            while (b == "\n");
            queue_byte(b);
          end
          queue_byte("\n");
        end
        9: queue_byte("/");
        10: begin
          count = $urandom_range(6, 1);
          for (int i = 0; i < count; i++) queue_byte($urandom_range(255, 0));
        end
        default: begin
          // A comment opening that may never be closed before end of input.
          if ($urandom_range(1, 0) != 0) queue_text("/*/");
          else queue_text("/*");
        end
      endcase
    end
    end_stream();
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: feeds text_q into the input port, one transfer per accepted byte.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (!rst_n) begin
      push            <= 1'b0;
      in_byte         <= 8'h00;
      in_end_of_input <= 1'b0;
      idle_cycles     = 0;
    end else begin
      if (push && !full) begin
        lex_byte(in_byte, in_end_of_input);
        idle_cycles = 0;
      end
      // The port is free for a new byte unless one is still waiting on full.
      if (!push || !full) begin
        if (text_q.size() != 0 && idle_cycles >= text_q[0].gap &&
            !(text_q[0].hold_for_drain && tokens_predicted != tokens_received)) begin
          next_src = text_q.pop_front();
          push            <= 1'b1;
          in_byte         <= next_src.value;
          in_end_of_input <= next_src.last;
        end else begin
          push <= 1'b0;
          idle_cycles++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: pops tokens with random stalls and checks them in order.
  // ---------------------------------------------------------------------------

  function automatic void check_field(string name, logic [63:0] expected, logic [63:0] actual);
    if (expected !== actual) begin
      mismatches++;
      $error("%s: expected %0d, actual %0d", name, expected, actual);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
      stall_left = 0;
      rx_max     = 19;
    end else begin
      if (pop && !empty) begin
        if (due_tokens.size() == 0) begin
          mismatches++;
          $error("token with nothing expected: type %0d start %0d length %0d",
                 out_token_type, out_start_pos, out_token_length);
        end else begin
          want = due_tokens.pop_front();
          check_field("token_type", want.ttype, out_token_type);
          check_field("word_code", want.code, out_word_code);
          check_field("start_pos", want.start, out_start_pos);
          check_field("token_length", want.len, out_token_length);
          check_field("run_last", want.last, out_run_last);
        end
        tokens_received <= tokens_received + 1;
        // Every so often switch between no stalls, short stalls and long ones.
        if (tokens_received % 97 == 96) begin
          case ($urandom_range(2, 0))
            0:       rx_max = 0;
            1:       rx_max = 2;
            default: rx_max = 19;
          endcase
        end
        stall_left = $urandom_range(rx_max, 0);
      end else if (!pop && stall_left > 0) begin
        stall_left--;
      end
      pop <= (stall_left == 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog
  // ---------------------------------------------------------------------------

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------

  initial begin
    int random_start;
    lex_reset();

    // Directed part. A word runs straight into a comment, the comment opening
    // slash-star-slash must not close it, a number is cut off by a line
    // comment holding a 0xFF byte, and a stream ends on a held slash.
    send_max = 2;
    queue_text("ab/*/*/9//");
    queue_byte(8'hFF);
    queue_byte("\n");
    queue_text("x/y");
    end_stream();
    // Every operator and punctuation character back to back.
    queue_text("+-*=,;{}()[]");
    end_stream();
    // A word that only looks like a keyword because of a trailing zero byte,
    // still pending at end of input.
    queue_text("if");
    queue_byte(8'h00);
    end_stream();
    queue_byte("/");
    end_stream();

    // A word far longer than the collected prefix: the letter at its tail
    // must still spoil the digit test.
    send_max = 0;
    queue_text(";\t");
    for (int i = 0; i < 20; i++) queue_byte("7");
    queue_byte("x");
    end_stream();

    // Random part. The first stream waits for the block to drain completely
    // before it starts, and so does a randomly chosen one in eight of those after it.
    random_start = text_q.size();
    drain_next = 1'b1;
    while (text_q.size() - random_start < RANDOM_BYTES) begin
      pick_send_pace();
      if ($urandom_range(7, 0) == 0) drain_next = 1'b1;
      queue_stream();
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Polling on the falling edge keeps these reads clear of the updates made
    // by the driver and monitor at the rising edge.
    do @(negedge clk);
    while (text_q.size() != 0 || push || due_tokens.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (mismatches == 0 && due_tokens.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
